FILE: hw/rtl/slc_pkg.sv
`timescale 1ns / 1ps

package slc_pkg;

	// Default line geometry and sprite limit.
	localparam int unsigned LINE_PIXELS_DEF      = 256;
	localparam int unsigned SPRITES_PER_LINE_DEF = 8;

	// Width of a sprite row footprint in zoom mode.
	localparam int unsigned COV_W = 16;

	// Item operation codes.
	typedef enum logic [1:0] {
		OP_NEW_LINE   = 2'd0,
		OP_SPRITE     = 2'd1,
		OP_READ_CLEAR = 2'd2,
		OP_NOP        = 2'd3
	} opcode_t;

	// Configuration register indexes.
	localparam logic [0:0] CFG_ZOOM  = 1'b0;
	localparam logic [0:0] CFG_SHIFT = 1'b1;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] sprite_x;
		logic [7:0] plane_a;
		logic [7:0] plane_b;
		logic [7:0] plane_c;
		logic [7:0] plane_d;
	} item_t;

	typedef struct packed {
		logic collision_flag;
		logic hit_now;
	} result_t;

	// Command from the pipeline control to the line state.
	typedef struct packed {
		logic    en;
		opcode_t op;
	} line_cmd_t;

endpackage

FILE: hw/rtl/slc_mask.sv
`timescale 1ns / 1ps

module slc_mask (
	input  logic [7:0]              plane_a,
	input  logic [7:0]              plane_b,
	input  logic [7:0]              plane_c,
	input  logic [7:0]              plane_d,
	input  logic                    zoom,
	output logic [slc_pkg::COV_W-1:0] cov
);
	import slc_pkg::*;

	logic [7:0] opaque;
	logic [7:0] rev;

	// A pixel is opaque when any plane has its bit set.
	assign opaque = plane_a | plane_b | plane_c | plane_d;

	// Reverse so that bit k is pixel k from the left, then double in zoom mode.
	always_comb begin
		cov = '0;
		for (int k = 0; k < 8; k++) begin
			rev[k] = opaque[7-k];
		end
		if (zoom) begin
			for (int k = 0; k < 8; k++) begin
				cov[2*k]   = rev[k];
				cov[2*k+1] = rev[k];
			end
		end else begin
			cov[7:0] = rev;
		end
	end

endmodule

FILE: hw/rtl/slc_line.sv
`timescale 1ns / 1ps

module slc_line #(
	parameter int unsigned LINE_PIXELS      = slc_pkg::LINE_PIXELS_DEF,
	parameter int unsigned SPRITES_PER_LINE = slc_pkg::SPRITES_PER_LINE_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  slc_pkg::line_cmd_t        cmd,
	input  logic [7:0]                sprite_x,
	input  logic [slc_pkg::COV_W-1:0] cov,
	input  logic                      shift_left_eight,
	output slc_pkg::result_t          res
);
	import slc_pkg::*;

	// The extended line starts eight pixels left of column zero and leaves
	// room for a full zoomed sprite past the right edge.
	localparam int unsigned EXT_W = LINE_PIXELS + 24;
	localparam int unsigned CNT_W = $clog2(SPRITES_PER_LINE + 1);

	logic [LINE_PIXELS-1:0] map_q;
	logic                   collided_q;
	logic [CNT_W-1:0]       count_q;

	logic [8:0]             shamt;
	logic [EXT_W-1:0]       placed_ext;
	logic [LINE_PIXELS-1:0] placed;
	logic                   take;
	logic                   hit;

	// Place the footprint on the extended line; clipping falls out of the slice.
	assign shamt      = {1'b0, sprite_x} + (shift_left_eight ? 9'd0 : 9'd8);
	assign placed_ext = EXT_W'(cov) << shamt;
	assign placed     = placed_ext[LINE_PIXELS+7:8];

	// A sprite row is evaluated only while the line is under its limit.
	assign take = cmd.en && (cmd.op == OP_SPRITE) && (count_q < CNT_W'(SPRITES_PER_LINE));
	assign hit  = take && ((map_q & placed) != '0);

	assign res.hit_now        = hit;
	assign res.collision_flag = collided_q | hit;

	// Coverage map, sprite count and sticky flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q      <= '0;
			collided_q <= 1'b0;
			count_q    <= '0;
		end else if (cmd.en) begin
			unique case (cmd.op)
				OP_NEW_LINE: begin
					map_q   <= '0;
					count_q <= '0;
				end
				OP_SPRITE: begin
					if (take) begin
						map_q   <= map_q | placed;
						count_q <= count_q + CNT_W'(1);
						if (hit) begin
							collided_q <= 1'b1;
						end
					end
				end
				OP_READ_CLEAR: begin
					collided_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	a_new_line_clears_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.en && cmd.op == OP_NEW_LINE |=> count_q == '0)
		else $error("sprite count not cleared by new line");

	a_read_clears_flag: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.en && cmd.op == OP_READ_CLEAR |=> !collided_q)
		else $error("collision flag not cleared by read");

	a_hit_sets_flag: assert property (@(posedge clk) disable iff (!arst_n)
		hit |=> collided_q)
		else $error("hit did not set collision flag");

	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(SPRITES_PER_LINE))
		else $error("sprite count exceeds line limit");

endmodule

FILE: hw/rtl/sprite_line_collision_top.sv
`timescale 1ns / 1ps

// Sprite collision detector for one scanline. Each transfer on the item
// channel is a new-line command, a sprite row (x position and four plane
// bytes), a read-and-clear of the sticky collision flag or a no-op, and each
// gives exactly one result carrying the flag and whether this row hit
// covered pixels. The block takes one item per clock cycle while the result
// is not stalled; an item passes the input register, then the single
// evaluation stage that reads, tests and updates the whole coverage map at
// once, then the result register. A stalled result holds the evaluation
// stage and the input channel until it is taken. The user must write zoom
// and the eight-pixel left shift through the configuration channel only
// while no item is in flight; the block does not enforce this. Coverage
// and the sprite count need no clearing pass: reset clears them at once.
module sprite_line_collision_top #(
	parameter int unsigned LINE_PIXELS      = slc_pkg::LINE_PIXELS_DEF,
	parameter int unsigned SPRITES_PER_LINE = slc_pkg::SPRITES_PER_LINE_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  slc_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output slc_pkg::result_t result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [0:0]       cfg_index,
	input  logic             cfg_data
);
	import slc_pkg::*;

	logic                 zoom_q;
	logic                 shift_q;
	logic                 valid_s1;
	item_t                item_s1;
	logic                 valid_s2;
	result_t              result_s2;
	logic                 advance;
	line_cmd_t            cmd;
	logic [COV_W-1:0]     cov;
	result_t              res;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zoom_q  <= 1'b0;
			shift_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_ZOOM:  zoom_q  <= cfg_data;
				CFG_SHIFT: shift_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// The evaluation stage moves forward whenever the result register frees.
	assign advance    = valid_s1 && (!valid_s2 || result_ready);
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	// Row footprint from the plane bytes.
	slc_mask u_mask (
		.plane_a (item_s1.plane_a),
		.plane_b (item_s1.plane_b),
		.plane_c (item_s1.plane_c),
		.plane_d (item_s1.plane_d),
		.zoom    (zoom_q),
		.cov     (cov)
	);

	assign cmd.en = advance;
	assign cmd.op = opcode_t'(item_s1.opcode);

	// Coverage map merge and collision state.
	slc_line #(
		.LINE_PIXELS      (LINE_PIXELS),
		.SPRITES_PER_LINE (SPRITES_PER_LINE)
	) u_line (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sprite_x         (item_s1.sprite_x),
		.cov              (cov),
		.shift_left_eight (shift_q),
		.res              (res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= res;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

	a_stall_holds_stage: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !result_ready |=> valid_s1 && $stable(item_s1))
		else $error("evaluation stage lost an item during a stall");

	a_advance_fills_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("advanced item did not reach the result register");

	a_no_accept_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !result_ready |-> !item_ready)
		else $error("item accepted while the pipeline is blocked");

endmodule
